[src/wsfp_pkg.sv]
package wsfp_pkg;

	localparam int unsigned LEN_W = 64;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;
	localparam logic [3:0] OPCODE_CONT = 4'h0;

	typedef struct packed {
		logic [1:0]       kind;
		logic             fin;
		logic [3:0]       opcode;
		logic             mask;
		logic [LEN_W-1:0] length;
		logic [7:0]       pbyte;
		logic             last;
	} result_t;

endpackage

[src/wsfp_parse.sv]
module wsfp_parse
	import wsfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte_s1,
	output logic       res_valid,
	output result_t    res
);

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	phase_t           phase_q, phase_d;
	logic             fin_q, fin_d;
	logic [3:0]       opcode_q, opcode_d;
	logic             mask_q, mask_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [LEN_W-1:0] idx_q, idx_d;
	logic [31:0]      key_q, key_d;
	logic [2:0]       cnt_q, cnt_d;
	logic             len_known;
	logic             hdr_done;
	logic             is_last;
	logic [7:0]       key_byte;

	always_comb begin
		phase_d   = phase_q;
		fin_d     = fin_q;
		opcode_d  = opcode_q;
		mask_d    = mask_q;
		len_d     = len_q;
		idx_d     = idx_q;
		key_d     = key_q;
		cnt_d     = cnt_q;
		len_known = 1'b0;
		hdr_done  = 1'b0;
		res_valid = 1'b0;
		res.kind  = KIND_HEADER;
		res.pbyte = 8'd0;
		res.last  = 1'b0;
		key_byte  = 8'd0;
		is_last   = (idx_q == len_q - {{(LEN_W-1){1'b0}}, 1'b1});

		unique case (phase_q)
			PH_SECOND: begin
				if (fin_q && opcode_q == OPCODE_CONT) begin
					mask_d    = 1'b0;
					len_d     = '0;
					phase_d   = PH_FIRST;
					res_valid = 1'b1;
					res.kind  = KIND_ERROR;
				end else begin
					mask_d = data_byte_s1[7];
					len_d  = '0;
					if (data_byte_s1[6:0] == LEN_CODE_16) begin
						phase_d = PH_EXTLEN;
						cnt_d   = 3'd1;
					end else if (data_byte_s1[6:0] == LEN_CODE_64) begin
						phase_d = PH_EXTLEN;
						cnt_d   = 3'd7;
					end else begin
						len_d     = {{(LEN_W-7){1'b0}}, data_byte_s1[6:0]};
						len_known = 1'b1;
					end
				end
			end
			PH_EXTLEN: begin
				len_d = {len_q[LEN_W-9:0], data_byte_s1};
				if (cnt_q != 3'd0) begin
					cnt_d = cnt_q - 3'd1;
				end else begin
					len_known = 1'b1;
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], data_byte_s1};
				if (cnt_q != 3'd0) begin
					cnt_d = cnt_q - 3'd1;
				end else begin
					hdr_done = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				if (mask_q) begin
					unique case (idx_q[1:0])
						2'd0: key_byte = key_q[31:24];
						2'd1: key_byte = key_q[23:16];
						2'd2: key_byte = key_q[15:8];
						default: key_byte = key_q[7:0];
					endcase
				end
				res_valid = 1'b1;
				res.kind  = KIND_PAYLOAD;
				res.pbyte = data_byte_s1 ^ key_byte;
				res.last  = is_last;
				if (is_last) begin
					phase_d = PH_FIRST;
					idx_d   = '0;
				end else begin
					idx_d = idx_q + {{(LEN_W-1){1'b0}}, 1'b1};
				end
			end
			default: begin
				fin_d    = data_byte_s1[7];
				opcode_d = data_byte_s1[3:0];
				phase_d  = PH_SECOND;
				cnt_d    = 3'd0;
			end
		endcase

		// With the length settled, a masked frame still needs its four key bytes.
		if (len_known) begin
			if (mask_d) begin
				phase_d = PH_KEY;
				cnt_d   = 3'd3;
				key_d   = '0;
			end else begin
				hdr_done = 1'b1;
			end
		end

		if (hdr_done) begin
			idx_d     = '0;
			phase_d   = (len_d == '0) ? PH_FIRST : PH_PAYLOAD;
			res_valid = 1'b1;
			res.kind  = KIND_HEADER;
			res.last  = (len_d == '0);
		end

		res.fin    = fin_d;
		res.opcode = opcode_d;
		res.mask   = mask_d;
		res.length = len_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_FIRST;
			fin_q    <= 1'b0;
			opcode_q <= 4'd0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			idx_q    <= '0;
			key_q    <= '0;
			cnt_q    <= 3'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			fin_q    <= fin_d;
			opcode_q <= opcode_d;
			mask_q   <= mask_d;
			len_q    <= len_d;
			idx_q    <= idx_d;
			key_q    <= key_d;
			cnt_q    <= cnt_d;
		end
	end

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_ERROR |->
			res.fin && res.opcode == OPCODE_CONT && res.length == '0 && !res.last)
		else $error("error result carries unexpected header fields");

	a_header_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_HEADER |-> res.last == (res.length == '0))
		else $error("header result end marker disagrees with length");

	a_payload_len: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> len_q != '0 && idx_q < len_q)
		else $error("payload phase with index outside frame");

	a_step_first: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_FIRST |=> phase_q == PH_SECOND)
		else $error("first header byte did not move on to second");

endmodule

[src/wsfp_out.sv]
module wsfp_out
	import wsfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             res_valid,
	input  result_t          res,
	input  logic             result_stall,
	output logic             ready,
	output logic             result_valid,
	output logic [1:0]       result_kind,
	output logic             final_flag,
	output logic [3:0]       opcode_value,
	output logic             mask_flag,
	output logic [LEN_W-1:0] payload_length,
	output logic [7:0]       payload_byte,
	output logic             last_of_frame
);

	logic    valid_q;
	result_t res_q;

	// The register may take a new beat when empty or when its beat leaves now.
	assign ready = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && step && res_valid) begin
			res_q <= res;
		end
	end

	assign result_valid   = valid_q;
	assign result_kind    = res_q.kind;
	assign final_flag     = res_q.fin;
	assign opcode_value   = res_q.opcode;
	assign mask_flag      = res_q.mask;
	assign payload_length = res_q.length;
	assign payload_byte   = res_q.pbyte;
	assign last_of_frame  = res_q.last;

	a_no_step_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> ready)
		else $error("parser stepped while the result register was held");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_stall |=> valid_q && $stable(res_q))
		else $error("stalled result beat changed");

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid |=> valid_q)
		else $error("result beat lost");

endmodule

[src/websocket_frame_parser.sv]
// Channel   Handshake                    Payload
// byte      byte_valid / byte_stall      data_byte
// result    result_valid / result_stall  result_kind, final_flag, opcode_value,
//                                        mask_flag, payload_length, payload_byte,
//                                        last_of_frame
//
// One byte is taken per clock while byte_stall is low; a byte is held in the input register
// and its result, if any, is then registered in the result register.
// The header parser and the 64-bit payload index compare sit between those two registers.
// Reset clears the parser to expect a new first header byte and empties both registers.
// A stall on the result side holds the result beat; the input register takes bytes while
// it is empty or the result register is free or draining; byte_stall rises otherwise.
module websocket_frame_parser
	import wsfp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  logic [7:0]       data_byte,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [1:0]       result_kind,
	output logic             final_flag,
	output logic [3:0]       opcode_value,
	output logic             mask_flag,
	output logic [LEN_W-1:0] payload_length,
	output logic [7:0]       payload_byte,
	output logic             last_of_frame
);

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       ready;
	logic       step;
	logic       res_valid;
	result_t    res;

	assign step       = valid_s1 && ready;
	assign byte_stall = valid_s1 && !ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!byte_stall && byte_valid) begin
			data_byte_s1 <= data_byte;
		end
	end

	wsfp_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.data_byte_s1 (data_byte_s1),
		.res_valid    (res_valid),
		.res          (res)
	);

	wsfp_out u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.res_valid      (res_valid),
		.res            (res),
		.result_stall   (result_stall),
		.ready          (ready),
		.result_valid   (result_valid),
		.result_kind    (result_kind),
		.final_flag     (final_flag),
		.opcode_value   (opcode_value),
		.mask_flag      (mask_flag),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.last_of_frame  (last_of_frame)
	);

endmodule
